// ===== rtl/tbnm_pkg.sv =====
// Shared types and constants of the tolerance-box nearest-match block.
package tbnm_pkg;

  // Fixed field widths.
  localparam int ID_W       = 16;
  localparam int TOL_W      = 8;
  localparam int CEIL_W     = 18;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 18;
  localparam int SQ_W       = 2 * TOL_W;

  // Reset values of the configuration registers.
  localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(5);
  localparam logic [CEIL_W-1:0] CEIL_RESET = CEIL_W'(999);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING   = CFG_IDX_W'(1);

  // Operation carried by an input item.
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // Control from the sequencer to the scoring pipeline.
  typedef struct packed {
    logic clear_best;
    logic rd_valid;
  } scan_ctrl_t;

  // Best match held by the scoring pipeline.
  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] id;
  } match_t;

endpackage

// ===== rtl/tbnm_if.sv =====
// Handshake channel interfaces: input items, result items and configuration writes.
interface tbnm_in_if #(
  parameter int FEAT_W = 12
);
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [FEAT_W-1:0] count_feature;
  logic [FEAT_W-1:0] first_distance;
  logic [FEAT_W-1:0] second_distance;
  logic [FEAT_W-1:0] third_distance;
  logic [15:0]       entry_id;

  modport source (output valid, mode, count_feature, first_distance, second_distance,
                  third_distance, entry_id, input ready);
  modport sink   (input valid, mode, count_feature, first_distance, second_distance,
                  third_distance, entry_id, output ready);
endinterface

interface tbnm_out_if;
  logic        valid;
  logic        ready;
  logic        match_found;
  logic [15:0] match_id;
  logic        table_full;

  modport source (output valid, match_found, match_id, table_full, input ready);
  modport sink   (input valid, match_found, match_id, table_full, output ready);
endinterface

interface tbnm_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [17:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/tbnm_store.sv =====
// Entry memory: one write port, one read port with a registered read.
module tbnm_store import tbnm_pkg::*; #(
  parameter int DEPTH   = 1024,
  parameter int ADDR_W  = 10,
  parameter int ENTRY_W = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  logic [ADDR_W-1:0]  waddr_i,
  input  logic [ENTRY_W-1:0] wdata_i,
  input  logic               re_i,
  input  logic [ADDR_W-1:0]  raddr_i,
  output logic [ENTRY_W-1:0] rdata_o,
  output logic               rvalid_o
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_q;
  logic               rvalid_q;

  // Storage array and read data register; contents need no reset.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // Read data valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= re_i;
    end
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;

endmodule

// ===== rtl/tbnm_score.sv =====
// Scoring pipeline: window test, squared distance and running best over one scan.
module tbnm_score import tbnm_pkg::*; #(
  parameter int FEAT_W  = 12,
  parameter int ENTRY_W = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scan_ctrl_t           ctrl_i,
  input  logic [ENTRY_W-1:0]   entry_i,
  input  logic [4*FEAT_W-1:0]  query_i,
  input  logic [TOL_W-1:0]     tolerance_i,
  input  logic [CEIL_W-1:0]    ceiling_i,
  output logic                 busy_o,
  output match_t               best_o
);

  localparam int CMP_W = (FEAT_W > TOL_W) ? FEAT_W : TOL_W;

  logic [FEAT_W-1:0] diff      [4];
  logic [3:0]        lane_in;
  logic [TOL_W-1:0]  d1_q      [4];
  logic              v1_q;
  logic              in1_q;
  logic [ID_W-1:0]   id1_q;
  logic [SQ_W-1:0]   sq2_q     [4];
  logic              v2_q;
  logic              in2_q;
  logic [ID_W-1:0]   id2_q;
  logic [CEIL_W-1:0] sum;
  logic [CEIL_W-1:0] best_d, best_q;
  match_t            match_d, match_q;

  // Stage one: absolute differences and the window test per feature.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      diff[k] = (entry_i[k*FEAT_W +: FEAT_W] >= query_i[k*FEAT_W +: FEAT_W])
              ? entry_i[k*FEAT_W +: FEAT_W] - query_i[k*FEAT_W +: FEAT_W]
              : query_i[k*FEAT_W +: FEAT_W] - entry_i[k*FEAT_W +: FEAT_W];
      lane_in[k] = CMP_W'(diff[k]) <= CMP_W'(tolerance_i);
    end
  end

  // Inside the window every difference fits the tolerance width, so only those bits go on.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      d1_q[k] <= TOL_W'(diff[k]);
    end
    in1_q <= &lane_in;
    id1_q <= entry_i[4*FEAT_W +: ID_W];
  end

  // Stage two: squares.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      sq2_q[k] <= d1_q[k] * d1_q[k];
    end
    in2_q <= in1_q;
    id2_q <= id1_q;
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.rd_valid;
      v2_q <= v1_q;
    end
  end

  // Stage three: sum of squares against the best so far; the earliest entry wins a tie.
  assign sum = CEIL_W'(sq2_q[0]) + CEIL_W'(sq2_q[1]) + CEIL_W'(sq2_q[2])
             + CEIL_W'(sq2_q[3]);

  always_comb begin
    best_d  = best_q;
    match_d = match_q;
    if (ctrl_i.clear_best) begin
      best_d  = ceiling_i;
      match_d = '0;
    end else if (v2_q && in2_q && (sum < best_q)) begin
      best_d        = sum;
      match_d.found = 1'b1;
      match_d.id    = id2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q  <= CEIL_RESET;
      match_q <= '0;
    end else begin
      best_q  <= best_d;
      match_q <= match_d;
    end
  end

  assign busy_o = v1_q | v2_q;
  assign best_o = match_q;

  // A squared item always came through stage one the cycle before.
  assert property (@(posedge clk_i) disable iff (!rst_ni) v2_q |-> $past(v1_q))
    else $error("stage two valid without stage one");
  // A candidate inside the window that beats the best so far is always recorded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && in2_q && !ctrl_i.clear_best && sum < best_q) |=> match_q.found)
    else $error("better candidate not recorded");
  // Starting a scan empties the best match.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear_best |=> (!match_q.found && match_q.id == '0))
    else $error("best match not cleared at scan start");

endmodule

// ===== rtl/tolerance_box_nearest_match.sv =====
// Top level of the tolerance-box nearest-match block: sequencer, registers and output stage.
// A load, a clear, a query on an empty table and an unused mode are each answered from the idle
// state. A query on a table of N entries scans the entry memory one entry per cycle through its
// single read port; each entry passes the registered read, the window test and the squares, the
// best match is settled, and once the pipeline has drained the result is loaded into the output
// register. One item is worked on at a time; the next input item is taken as soon as the
// sequencer is idle and the output register is free or being emptied. The entry memory needs no
// clearing pass: only entries below the fill count are ever read.
module tolerance_box_nearest_match import tbnm_pkg::*; #(
  parameter int TABLE_DEPTH  = 1024,
  parameter int FEATURE_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tbnm_in_if.sink     in_i,
  tbnm_out_if.source  out_o,
  tbnm_cfg_if.sink    cfg_i
);

  localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W = 4 * FEATURE_BITS + ID_W;

  state_e                  state_d, state_q;
  logic [CNT_W-1:0]        cnt_d, cnt_q;
  logic [ADDR_W-1:0]       addr_d, addr_q;
  logic [4*FEATURE_BITS-1:0] query_q;
  logic [4*FEATURE_BITS-1:0] in_feat;
  logic [TOL_W-1:0]        tol_q;
  logic [CEIL_W-1:0]       ceil_q;
  logic                    in_ready;
  logic                    in_acc;
  logic                    out_free;
  logic                    out_load;
  logic                    res_full;
  match_t                  res_match;
  logic                    out_valid_q;
  logic                    out_full_q;
  match_t                  out_match_q;
  logic                    mem_we;
  logic                    rd_en;
  logic                    q_load;
  logic                    tbl_full;
  logic                    last_addr;
  logic [ENTRY_W-1:0]      rd_data;
  logic                    rd_valid;
  logic                    score_busy;
  scan_ctrl_t              scan_ctrl;
  match_t                  best;

  assign in_feat  = {in_i.third_distance, in_i.second_distance, in_i.first_distance,
                     in_i.count_feature};
  assign in_acc   = in_i.valid & in_ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign tbl_full = cnt_q == CNT_W'(TABLE_DEPTH);
  assign last_addr = (CNT_W'(addr_q) + CNT_W'(1)) == cnt_q;

  // Entry memory.
  tbnm_store #(
    .DEPTH   (TABLE_DEPTH),
    .ADDR_W  (ADDR_W),
    .ENTRY_W (ENTRY_W)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (mem_we),
    .waddr_i  (cnt_q[ADDR_W-1:0]),
    .wdata_i  ({in_i.entry_id, in_feat}),
    .re_i     (rd_en),
    .raddr_i  (addr_q),
    .rdata_o  (rd_data),
    .rvalid_o (rd_valid)
  );

  assign scan_ctrl.clear_best = q_load;
  assign scan_ctrl.rd_valid   = rd_valid;

  // Scoring pipeline.
  tbnm_score #(
    .FEAT_W  (FEATURE_BITS),
    .ENTRY_W (ENTRY_W)
  ) u_score (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (scan_ctrl),
    .entry_i     (rd_data),
    .query_i     (query_q),
    .tolerance_i (tol_q),
    .ceiling_i   (ceil_q),
    .busy_o      (score_busy),
    .best_o      (best)
  );

  // Sequencer: next state and control.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    addr_d    = addr_q;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    res_full  = 1'b0;
    res_match = '0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    q_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = out_free;
        if (in_i.valid && out_free) begin
          unique case (mode_e'(in_i.mode))
            MODE_LOAD: begin
              out_load = 1'b1;
              if (tbl_full) begin
                res_full = 1'b1;
              end else begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + CNT_W'(1);
              end
            end
            MODE_QUERY: begin
              if (cnt_q == '0) begin
                out_load = 1'b1;
              end else begin
                q_load  = 1'b1;
                addr_d  = '0;
                state_d = ST_SCAN;
              end
            end
            MODE_CLEAR: begin
              out_load = 1'b1;
              cnt_d    = '0;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        rd_en  = 1'b1;
        addr_d = addr_q + ADDR_W'(1);
        if (last_addr) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid && !score_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          res_match = best;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      addr_q  <= addr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload and latched query.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_full_q  <= res_full;
      out_match_q <= res_match;
    end
    if (q_load) begin
      query_q <= in_feat;
    end
  end

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q  <= TOL_RESET;
      ceil_q <= CEIL_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_TOLERANCE) begin
        tol_q <= TOL_W'(cfg_i.data);
      end else if (cfg_i.index == CFG_CEILING) begin
        ceil_q <= CEIL_W'(cfg_i.data);
      end
    end
  end

  assign cfg_i.ready       = 1'b1;
  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.match_found = out_match_q.found;
  assign out_o.match_id    = out_match_q.id;
  assign out_o.table_full  = out_full_q;

  // The fill count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");
  // Items are taken only by the idle sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |-> state_q == ST_IDLE)
    else $error("item accepted while busy");
  // A scan only runs over a non-empty table.
  assert property (@(posedge clk_i) disable iff (!rst_ni) state_q == ST_SCAN |-> cnt_q != '0)
    else $error("scan over an empty table");
  // The result of a query is taken only once the pipeline has drained.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> (!rd_valid && !score_busy))
    else $error("result taken before pipeline drained");

endmodule

// ===== dv/tolerance_box_nearest_match_tb.sv =====
// Self-checking testbench of the tolerance-box nearest-match block: directed rows, random items.
module tolerance_box_nearest_match_tb;
  import tbnm_pkg::*;

  localparam int DEPTH         = 1024;
  localparam int FEAT_W        = 12;
  localparam int FEAT_MAX      = (1 << FEAT_W) - 1;
  localparam int CEIL_MAX      = (1 << CEIL_W) - 1;
  localparam int TOL_MAX       = (1 << TOL_W) - 1;
  localparam int IDLE_PCT      = 18;
  localparam int STALL_LIMIT   = 8000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_ITEMS  = 560;
  localparam int DIR_ROWS      = 23;

  // The fourth mode code is not an operation; the block answers it with an empty result.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Register indexes past the two real registers; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(15);

  typedef struct packed {
    logic [MODE_W-1:0]      mode;
    logic [3:0][FEAT_W-1:0] feat;
    logic [ID_W-1:0]        id;
  } search_item_t;

  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] id;
    logic            full;
  } match_result_t;

  typedef struct {
    logic [MODE_W-1:0] mode;
    int                f0;
    int                f1;
    int                f2;
    int                f3;
    int                id;
    bit                typed;
    bit                e_found;
    int                e_id;
    bit                e_full;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tbnm_in_if #(.FEAT_W(FEAT_W)) in_if ();
  tbnm_out_if                   out_if ();
  tbnm_cfg_if                   cfg_if ();

  tolerance_box_nearest_match #(
    .TABLE_DEPTH  (DEPTH),
    .FEATURE_BITS (FEAT_W)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #10 clk_i = ~clk_i;

  // Pattern table and registers as the block should hold them.
  logic [3:0][FEAT_W-1:0] stored_feat [DEPTH];
  logic [ID_W-1:0]        stored_id   [DEPTH];
  int unsigned            stored_count;
  logic [TOL_W-1:0]       cur_tolerance;
  logic [CEIL_W-1:0]      cur_ceiling;

  match_result_t expected_q [$];
  int unsigned   n_errors     = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   random_count = 0;
  bit            calm         = 1'b0;

  // Directed rows: extremes, every operation, ties, window edges, clear and the unused mode.
  // Rows with typed = 1 carry their expected result; the rest are predicted.
  directed_row_t directed_rows [DIR_ROWS] = '{
    '{MODE_QUERY,  0,     0,     0,     0,     'hBEEF, 1, 0, 0,      0},
    '{MODE_UNUSED, 4095,  4095,  4095,  4095,  'hFFFF, 1, 0, 0,      0},
    '{MODE_LOAD,   0,     0,     0,     0,     'h0000, 1, 0, 0,      0},
    '{MODE_LOAD,   4095,  4095,  4095,  4095,  'hFFFF, 1, 0, 0,      0},
    '{MODE_LOAD,   100,   200,   300,   400,   'h1234, 1, 0, 0,      0},
    '{MODE_LOAD,   102,   198,   303,   400,   'h5678, 1, 0, 0,      0},
    '{MODE_LOAD,   100,   200,   300,   400,   'hAAAA, 1, 0, 0,      0},
    '{MODE_QUERY,  0,     0,     0,     0,     'h4321, 1, 1, 'h0000, 0},
    '{MODE_QUERY,  4095,  4095,  4095,  4095,  'h0000, 1, 1, 'hFFFF, 0},
    '{MODE_QUERY,  100,   200,   300,   400,   'h0000, 0, 0, 0,      0},
    '{MODE_QUERY,  101,   199,   301,   400,   'h0000, 0, 0, 0,      0},
    '{MODE_QUERY,  106,   200,   300,   400,   'h0000, 0, 0, 0,      0},
    '{MODE_QUERY,  105,   200,   300,   400,   'h0000, 0, 0, 0,      0},
    '{MODE_QUERY,  3,     4,     5,     0,     'h0000, 0, 0, 0,      0},
    '{MODE_QUERY,  6,     0,     0,     0,     'h0000, 0, 0, 0,      0},
    '{MODE_QUERY,  2048,  1024,  512,   256,   'h0000, 0, 0, 0,      0},
    '{MODE_LOAD,   'hAAA, 'h555, 'hAAA, 'h555, 'h5555, 1, 0, 0,      0},
    '{MODE_QUERY,  'hAAA, 'h555, 'hAAA, 'h555, 'h0000, 1, 1, 'h5555, 0},
    '{MODE_CLEAR,  4095,  4095,  4095,  4095,  'hFFFF, 1, 0, 0,      0},
    '{MODE_QUERY,  100,   200,   300,   400,   'h0000, 1, 0, 0,      0},
    '{MODE_LOAD,   100,   200,   300,   400,   'h0F0F, 1, 0, 0,      0},
    '{MODE_QUERY,  100,   200,   300,   400,   'h0000, 0, 0, 0,      0},
    '{MODE_CLEAR,  0,     0,     0,     0,     'h0000, 1, 0, 0,      0}
  };

  // Works out the result of one item and updates the table as the block should.
  function automatic match_result_t predict_match(search_item_t it);
    match_result_t res;
    int unsigned   best;
    int unsigned   score;
    int unsigned   diff;
    bit            in_window;
    res = '0;
    case (it.mode)
      MODE_LOAD: begin
        if (stored_count < DEPTH) begin
          stored_feat[stored_count] = it.feat;
          stored_id[stored_count]   = it.id;
          stored_count++;
        end else begin
          res.full = 1'b1;
        end
      end
      MODE_QUERY: begin
        best = cur_ceiling;
        for (int i = 0; i < stored_count; i++) begin
          in_window = 1'b1;
          score     = 0;
          for (int k = 0; k < 4; k++) begin
            diff = (stored_feat[i][k] > it.feat[k]) ? stored_feat[i][k] - it.feat[k]
                                                    : it.feat[k] - stored_feat[i][k];
            if (diff > cur_tolerance) in_window = 1'b0;
            score += diff * diff;
          end
          // Strictly smaller only, so the earliest of equal scores is kept.
          if (in_window && score < best) begin
            best      = score;
            res.found = 1'b1;
            res.id    = stored_id[i];
          end
        end
      end
      MODE_CLEAR: begin
        stored_count = 0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Feature values lean towards both ends of the range.
  function automatic logic [FEAT_W-1:0] random_feature();
    case ($urandom_range(9))
      0:       return '0;
      1:       return FEAT_W'(FEAT_MAX);
      default: return FEAT_W'($urandom_range(FEAT_MAX));
    endcase
  endfunction

  function automatic logic [FEAT_W-1:0] near_feature(logic [FEAT_W-1:0] base, int spread);
    int v;
    v = int'($urandom_range(2 * spread)) - spread + int'(base);
    if (v < 0) v = 0;
    if (v > FEAT_MAX) v = FEAT_MAX;
    return FEAT_W'(v);
  endfunction

  function automatic search_item_t random_item(logic [MODE_W-1:0] mode);
    search_item_t it;
    it.mode = mode;
    for (int k = 0; k < 4; k++) it.feat[k] = random_feature();
    it.id = ID_W'($urandom);
    return it;
  endfunction

  // Features around a stored pattern; the spread reaches one step past the window.
  function automatic search_item_t near_item(logic [MODE_W-1:0] mode, bit exact);
    search_item_t it;
    int unsigned  pick;
    it   = random_item(mode);
    pick = $urandom_range(stored_count - 1);
    for (int k = 0; k < 4; k++) begin
      it.feat[k] = exact ? stored_feat[pick][k]
                         : near_feature(stored_feat[pick][k], int'(cur_tolerance) + 1);
    end
    return it;
  endfunction

  // Presents one item, idling now and then, and records its expected result on acceptance.
  task automatic send_item(search_item_t it, bit typed, match_result_t typed_res);
    match_result_t pred;
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.mode            <= it.mode;
    in_if.count_feature   <= it.feat[0];
    in_if.first_distance  <= it.feat[1];
    in_if.second_distance <= it.feat[2];
    in_if.third_distance  <= it.feat[3];
    in_if.entry_id        <= it.id;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pred = predict_match(it);
    expected_q.insert(expected_q.size(), typed ? typed_res : pred);
  endtask

  task automatic send_random(search_item_t it);
    send_item(it, 1'b0, '0);
    if (it.mode != MODE_UNUSED) random_count++;
  endtask

  // Drops valid and waits until every result has come back.
  task automatic wait_idle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    if (idx == CFG_TOLERANCE) begin
      cur_tolerance = value[TOL_W-1:0];
    end else if (idx == CFG_CEILING) begin
      cur_ceiling = value[CEIL_W-1:0];
    end
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Register settings per phase; the first phases take the extremes.
  task automatic set_phase_regs(int phase);
    logic [TOL_W-1:0]      tol;
    logic [CEIL_W-1:0]     ceil_val;
    logic [CFG_DATA_W-1:0] data;
    case (phase)
      0: begin tol = '0;               ceil_val = CEIL_W'(CEIL_MAX); end
      1: begin tol = TOL_W'(TOL_MAX);  ceil_val = CEIL_W'(CEIL_MAX); end
      2: begin tol = TOL_W'(5);        ceil_val = '0;                end
      3: begin tol = TOL_W'(10);       ceil_val = CEIL_W'(1);        end
      default: begin
        case ($urandom_range(5))
          0:       tol = '0;
          1:       tol = TOL_W'(TOL_MAX);
          2, 3:    tol = TOL_W'($urandom_range(1, 8));
          default: tol = TOL_W'($urandom_range(TOL_MAX));
        endcase
        case ($urandom_range(5))
          0:       ceil_val = '0;
          1:       ceil_val = CEIL_W'(CEIL_MAX);
          2:       ceil_val = CEIL_W'(999);
          3, 4:    ceil_val = CEIL_W'($urandom_range(4 * int'(tol) * int'(tol) + 4));
          default: ceil_val = CEIL_W'($urandom_range(CEIL_MAX));
        endcase
      end
    endcase
    // Bits above the tolerance field are random and must be dropped by the block.
    data             = CFG_DATA_W'($urandom);
    data[TOL_W-1:0]  = tol;
    write_reg(CFG_TOLERANCE, data);
    write_reg(CFG_CEILING, CFG_DATA_W'(ceil_val));
    if (phase % 5 == 2) begin
      write_reg(($urandom_range(1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_DATA_W'($urandom));
    end
  endtask

  // Mostly a clear, a small table and searches around its patterns; sometimes loose noise.
  task automatic run_phase();
    search_item_t it;
    int unsigned  roll;
    if ($urandom_range(99) < 80) begin
      send_random(random_item(MODE_CLEAR));
      repeat ($urandom_range(1, 24)) begin
        roll = $urandom_range(99);
        if (stored_count > 0 && roll < 15) begin
          it = near_item(MODE_LOAD, 1'b1);
        end else if (stored_count > 0 && roll < 55) begin
          it = near_item(MODE_LOAD, 1'b0);
        end else begin
          it = random_item(MODE_LOAD);
        end
        send_random(it);
      end
      repeat ($urandom_range(3, 10)) begin
        roll = $urandom_range(99);
        if (roll < 70) begin
          it = near_item(MODE_QUERY, 1'b0);
        end else if (roll < 80) begin
          it = near_item(MODE_QUERY, 1'b1);
        end else if (roll < 90) begin
          it = random_item(MODE_QUERY);
        end else if (roll < 95) begin
          it = random_item(MODE_UNUSED);
        end else begin
          it = random_item(MODE_LOAD);
        end
        send_random(it);
      end
    end else begin
      repeat ($urandom_range(6, 15)) begin
        it = random_item(MODE_W'($urandom_range(3)));
        if (it.mode == MODE_QUERY && stored_count > 0 && $urandom_range(1) != 0) begin
          it = near_item(MODE_QUERY, 1'b0);
        end
        send_random(it);
      end
    end
  endtask

  // Result receiver stalls at random, except in the calm stretch.
  always @(negedge clk_i) begin
    out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    match_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        if (n_errors < MAX_REPORTS) begin
          $display("%0t: result with nothing expected: found=%0b id=%h full=%0b",
                   $time, out_if.match_found, out_if.match_id, out_if.table_full);
        end
        n_errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_if.match_found !== want.found || out_if.match_id !== want.id ||
            out_if.table_full !== want.full) begin
          if (n_errors < MAX_REPORTS) begin
            $display("%0t: mismatch: expected found=%0b id=%h full=%0b, %s",
                     $time, want.found, want.id, want.full,
                     $sformatf("got found=%0b id=%h full=%0b",
                               out_if.match_found, out_if.match_id, out_if.table_full));
          end
          n_errors++;
        end
      end
    end
  end

  // Ends the run if no channel moves an item for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    search_item_t  it;
    match_result_t typed_res;
    int            phase;

    rst_ni                = 1'b0;
    in_if.valid           = 1'b0;
    in_if.mode            = '0;
    in_if.count_feature   = '0;
    in_if.first_distance  = '0;
    in_if.second_distance = '0;
    in_if.third_distance  = '0;
    in_if.entry_id        = '0;
    out_if.ready          = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = '0;
    cfg_if.data           = '0;
    stored_count          = 0;
    cur_tolerance         = TOL_RESET;
    cur_ceiling           = CEIL_RESET;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows under the reset settings.
    foreach (directed_rows[r]) begin
      it.mode    = directed_rows[r].mode;
      it.feat[0] = FEAT_W'(directed_rows[r].f0);
      it.feat[1] = FEAT_W'(directed_rows[r].f1);
      it.feat[2] = FEAT_W'(directed_rows[r].f2);
      it.feat[3] = FEAT_W'(directed_rows[r].f3);
      it.id      = ID_W'(directed_rows[r].id);
      typed_res.found = directed_rows[r].e_found;
      typed_res.id    = ID_W'(directed_rows[r].e_id);
      typed_res.full  = directed_rows[r].e_full;
      send_item(it, directed_rows[r].typed, typed_res);
    end

    // Random phases, each under fresh register settings.
    phase = 0;
    while (random_count < RANDOM_ITEMS) begin
      wait_idle();
      set_phase_regs(phase);
      calm = (phase >= 6 && phase < 12);
      run_phase();
      phase++;
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== tolerance_box_nearest_match.f =====
rtl/tbnm_pkg.sv
rtl/tbnm_if.sv
rtl/tbnm_store.sv
rtl/tbnm_score.sv
rtl/tolerance_box_nearest_match.sv
dv/tolerance_box_nearest_match_tb.sv
